FILE: rtl/core/polyline_level_crossing_arrows_macros.svh
// Assertion macros for the polyline level-crossing block
`ifndef POLYLINE_LEVEL_CROSSING_ARROWS_MACROS_SVH
`define POLYLINE_LEVEL_CROSSING_ARROWS_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PLCA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PLCA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PLCA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define PLCA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/core/plca_pkg.sv
// Shared widths and constants of the polyline level-crossing block
package plca_pkg;
	localparam int COORD_W = 32;
	localparam int DIR_W = 16;
	localparam int FRAC_Q14 = 14;
	localparam logic [31:0] SPACING_RESET = 32'd65536;
endpackage

FILE: rtl/core/plca_if.sv
// Channel interfaces: configuration, polyline points and crossing results
interface plca_cfg_if import plca_pkg::*; ();
	logic valid;
	logic ready;
	logic [COORD_W-1:0] level_spacing;
	modport source (output valid, output level_spacing, input ready);
	modport sink (input valid, input level_spacing, output ready);
endinterface

interface plca_point_if import plca_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [COORD_W-1:0] coord_x;
	logic signed [COORD_W-1:0] coord_y;
	logic signed [COORD_W-1:0] level_value;
	logic curve_start;
	modport source (output valid, output coord_x, output coord_y, output level_value,
		output curve_start, input ready);
	modport sink (input valid, input coord_x, input coord_y, input level_value,
		input curve_start, output ready);
endinterface

interface plca_result_if import plca_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [COORD_W-1:0] pos_x;
	logic signed [COORD_W-1:0] pos_y;
	logic signed [DIR_W-1:0] dir_x;
	logic signed [DIR_W-1:0] dir_y;
	logic last_of_segment;
	logic truncated;
	modport source (output valid, output pos_x, output pos_y, output dir_x, output dir_y,
		output last_of_segment, output truncated, input ready);
	modport sink (input valid, input pos_x, input pos_y, input dir_x, input dir_y,
		input last_of_segment, input truncated, output ready);
endinterface

FILE: rtl/core/polyline_level_crossing_arrows.sv
// Top level of the polyline level-crossing block
// Usage:
// points carries one polyline point per transaction (x, y, level, curve_start).
// results carries one crossing per transaction: position, unit direction in
// Q1.14, last_of_segment and truncated. cfg, which is always ready, writes
// level_spacing; the user must do so only while the block is idle (unchecked).
// A point that starts a curve, or the first point after reset, is stored and
// gives no result. Otherwise one shared restoring divider, one 32x32
// multiplier and a 32-step square root handle the point: two divisions find
// the crossed levels; when the segment has nonzero length, the direction is
// normalised, squared, rooted and divided per axis; then each crossing takes a
// multiply and a division per axis, up to MAX_CROSSINGS crossings.
// points.ready is high only while the sequencer waits for a point; the last
// result of a segment waits in the output register while the next point is
// taken. A stalled receiver holds the sequencer before each further result.
// Reset clears the stored point and the output valid flag, and sets
// level_spacing to 1.0.
`include "polyline_level_crossing_arrows_macros.svh"
module polyline_level_crossing_arrows import plca_pkg::*; #(
	parameter int MAX_CROSSINGS = 64
) (
	input logic clk,
	input logic arst_n,
	plca_cfg_if.sink cfg,
	plca_point_if.sink points,
	plca_result_if.source results
);
	localparam int CntW = $clog2(MAX_CROSSINGS + 1);

	typedef enum logic [4:0] {
		ST_IDLE, ST_DIVF, ST_DIVL, ST_DIV, ST_BOUNDS, ST_CHECK, ST_NORM, ST_SQX, ST_SQY,
		ST_SQSUM, ST_SQRT, ST_DIRX, ST_DIRY, ST_DIRDONE, ST_MULX, ST_DIVPX, ST_POSX,
		ST_DIVPY, ST_POSY, ST_EMIT
	} state_t;

	state_t state_q, ret_q;
	logic [31:0] spacing_q;
	logic signed [31:0] prev_x_q, prev_y_q, prev_l_q;
	logic have_prev_q;
	logic signed [31:0] cur_x_q, cur_y_q, cur_l_q;
	logic [31:0] div_rem_q, div_d_q;
	logic [32:0] div_bits_q, div_quo_q;
	logic [5:0] div_cnt_q;
	logic [31:0] qf_q, rf_q;
	logic signed [33:0] ff_q, cf_q, fll_q, cl_q;
	logic signed [34:0] num_q;
	logic up_q;
	logic [31:0] magx_q, magy_q;
	logic dnegx_q, dnegy_q, vnegx_q, vnegy_q;
	logic [32:0] ax_q, ay_q;
	logic [63:0] mul_q, sum_q, rt_q;
	logic [62:0] bit_q;
	logic signed [15:0] dx_q, dy_q;
	logic signed [31:0] px_q, py_q;
	logic [CntW-1:0] cnt_q, idx_q;
	logic trunc_q;
	logic out_valid_q;
	logic signed [31:0] o_px_q, o_py_q;
	logic signed [15:0] o_dx_q, o_dy_q;
	logic o_last_q, o_trunc_q;

	logic [31:0] s_eff, f_abs, l_abs, un, ud;
	logic signed [32:0] den, diffx, diffy;
	logic [32:0] div_rem2;
	logic div_ge;
	logic [63:0] ld_dividend;
	logic [31:0] ld_divisor;
	logic ld_en;
	logic [31:0] mul_a, mul_b;
	logic mul_en;
	logic [32:0] m_val;
	logic [63:0] sq_t;
	logic rf_nz, rl_nz;
	logic signed [33:0] qf_s, ql_s, ff_c, cf_c, fll_c, cl_c;
	logic signed [34:0] f_e, l_e, base_f, base_l;
	logic signed [33:0] sel_fl, sel_la, sel_lo, sel_hi;
	logic signed [34:0] total;
	logic no_cross, last_c;
	logic signed [31:0] py_c;
	logic emit_go;
	logic start_acc, dir_ok, trunc_ok;

	assign s_eff = (spacing_q == 32'd0) ? 32'd1 : spacing_q;
	assign f_abs = prev_l_q[31] ? (~prev_l_q + 32'd1) : prev_l_q;
	assign l_abs = cur_l_q[31] ? (~cur_l_q + 32'd1) : cur_l_q;
	assign den = {prev_l_q[31], prev_l_q} - {cur_l_q[31], cur_l_q};
	assign ud = den[32] ? 32'(-den) : 32'(den);
	assign un = up_q ? 32'(-num_q) : 32'(num_q);
	assign diffx = {prev_x_q[31], prev_x_q} - {cur_x_q[31], cur_x_q};
	assign diffy = {prev_y_q[31], prev_y_q} - {cur_y_q[31], cur_y_q};

	assign div_rem2 = {div_rem_q, div_bits_q[32]};
	assign div_ge = div_rem2 >= {1'b0, div_d_q};

	always_comb begin
		ld_en = 1'b1;
		ld_dividend = 64'd0;
		ld_divisor = s_eff;
		case (state_q)
			ST_DIVF: ld_dividend = {32'd0, f_abs};
			ST_DIVL: ld_dividend = {32'd0, l_abs};
			ST_DIRX: begin
				ld_dividend = (64'(ax_q) << FRAC_Q14) + (rt_q >> 1);
				ld_divisor = rt_q[31:0];
			end
			ST_DIRY: begin
				ld_dividend = (64'(ay_q) << FRAC_Q14) + (rt_q >> 1);
				ld_divisor = rt_q[31:0];
			end
			ST_DIVPX, ST_DIVPY: begin
				ld_dividend = mul_q + 64'(ud >> 1);
				ld_divisor = ud;
			end
			default: ld_en = 1'b0;
		endcase
	end

	always_comb begin
		mul_en = 1'b1;
		mul_a = un;
		mul_b = magx_q;
		case (state_q)
			ST_SQX: begin
				mul_a = ax_q[31:0];
				mul_b = ax_q[31:0];
			end
			ST_SQY: begin
				mul_a = ay_q[31:0];
				mul_b = ay_q[31:0];
			end
			ST_MULX: mul_b = magx_q;
			ST_POSX: mul_b = magy_q;
			default: mul_en = 1'b0;
		endcase
	end

	assign m_val = (ax_q > ay_q) ? ax_q : ay_q;
	assign sq_t = rt_q + {1'b0, bit_q};

	assign rf_nz = rf_q != 32'd0;
	assign rl_nz = div_rem_q != 32'd0;
	assign qf_s = {2'b00, qf_q};
	assign ql_s = {2'b00, div_quo_q[31:0]};
	assign ff_c = prev_l_q[31] ? -(qf_s + 34'(rf_nz)) : qf_s;
	assign cf_c = prev_l_q[31] ? -qf_s : qf_s + 34'(rf_nz);
	assign fll_c = cur_l_q[31] ? -(ql_s + 34'(rl_nz)) : ql_s;
	assign cl_c = cur_l_q[31] ? -ql_s : ql_s + 34'(rl_nz);
	assign f_e = 35'(prev_l_q);
	assign l_e = 35'(cur_l_q);
	assign base_f = prev_l_q[31] ? f_e + {3'b000, rf_q}
		: f_e - {3'b000, rf_q} + (rf_nz ? {3'b000, s_eff} : 35'sd0);
	assign base_l = cur_l_q[31] ? l_e + {3'b000, div_rem_q}
		: l_e - {3'b000, div_rem_q} + (rl_nz ? {3'b000, s_eff} : 35'sd0);

	assign sel_fl = up_q ? ff_q : cf_q;
	assign sel_la = up_q ? fll_q : cl_q;
	assign sel_lo = up_q ? cf_q : cl_q;
	assign sel_hi = up_q ? fll_q : ff_q;
	assign total = 35'(sel_hi) - 35'(sel_lo) + 35'sd1;
	assign no_cross = (sel_fl == sel_la) || (sel_hi < sel_lo);
	assign last_c = idx_q == CntW'(cnt_q - 1'b1);
	assign py_c = dnegy_q ? (cur_y_q - div_quo_q[31:0]) : (cur_y_q + div_quo_q[31:0]);
	assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			spacing_q <= SPACING_RESET;
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_l_q <= '0;
			have_prev_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				spacing_q <= cfg.level_spacing;
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (mul_en) begin
				mul_q <= 64'(mul_a) * 64'(mul_b);
			end
			if (ld_en) begin
				div_rem_q <= {1'b0, ld_dividend[63:33]};
				div_bits_q <= ld_dividend[32:0];
				div_d_q <= ld_divisor;
				div_cnt_q <= '0;
				state_q <= ST_DIV;
			end
			case (state_q)
				ST_IDLE: begin
					if (points.valid) begin
						if (points.curve_start || !have_prev_q) begin
							prev_x_q <= points.coord_x;
							prev_y_q <= points.coord_y;
							prev_l_q <= points.level_value;
							have_prev_q <= 1'b1;
						end else begin
							cur_x_q <= points.coord_x;
							cur_y_q <= points.coord_y;
							cur_l_q <= points.level_value;
							state_q <= ST_DIVF;
						end
					end
				end
				ST_DIVF: ret_q <= ST_DIVL;
				ST_DIVL: begin
					qf_q <= div_quo_q[31:0];
					rf_q <= div_rem_q;
					ret_q <= ST_BOUNDS;
				end
				ST_DIV: begin
					div_rem_q <= div_ge ? 32'(div_rem2 - {1'b0, div_d_q}) : div_rem2[31:0];
					div_quo_q <= {div_quo_q[31:0], div_ge};
					div_bits_q <= div_bits_q << 1;
					div_cnt_q <= div_cnt_q + 6'd1;
					if (div_cnt_q == 6'd32) begin
						state_q <= ret_q;
					end
				end
				ST_BOUNDS: begin
					ff_q <= ff_c;
					cf_q <= cf_c;
					fll_q <= fll_c;
					cl_q <= cl_c;
					up_q <= cur_l_q > prev_l_q;
					num_q <= ((cur_l_q > prev_l_q) ? base_f : base_l) - l_e;
					dnegx_q <= diffx[32];
					dnegy_q <= diffy[32];
					magx_q <= diffx[32] ? 32'(-diffx) : 32'(diffx);
					magy_q <= diffy[32] ? 32'(-diffy) : 32'(diffy);
					ax_q <= {1'b0, diffx[32] ? 32'(-diffx) : 32'(diffx)};
					ay_q <= {1'b0, diffy[32] ? 32'(-diffy) : 32'(diffy)};
					vnegx_q <= (cur_l_q > prev_l_q) ? (!diffx[32] && diffx != 33'sd0) : diffx[32];
					vnegy_q <= (cur_l_q > prev_l_q) ? (!diffy[32] && diffy != 33'sd0) : diffy[32];
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (no_cross) begin
						prev_x_q <= cur_x_q;
						prev_y_q <= cur_y_q;
						prev_l_q <= cur_l_q;
						state_q <= ST_IDLE;
					end else begin
						trunc_q <= total > 35'(MAX_CROSSINGS);
						cnt_q <= (total > 35'(MAX_CROSSINGS)) ? CntW'(MAX_CROSSINGS)
							: total[CntW-1:0];
						idx_q <= '0;
						if (ax_q == 33'd0 && ay_q == 33'd0) begin
							dx_q <= '0;
							dy_q <= '0;
							state_q <= ST_MULX;
						end else begin
							state_q <= ST_NORM;
						end
					end
				end
				ST_NORM: begin
					if (m_val >= 33'h040000000) begin
						ax_q <= ax_q >> 1;
						ay_q <= ay_q >> 1;
					end else if (m_val < 33'h020000000) begin
						ax_q <= ax_q << 1;
						ay_q <= ay_q << 1;
					end else begin
						state_q <= ST_SQX;
					end
				end
				ST_SQX: state_q <= ST_SQY;
				ST_SQY: begin
					sum_q <= mul_q;
					state_q <= ST_SQSUM;
				end
				ST_SQSUM: begin
					sum_q <= sum_q + mul_q;
					rt_q <= '0;
					bit_q <= {1'b1, 62'd0};
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (sum_q >= sq_t) begin
						sum_q <= sum_q - sq_t;
						rt_q <= (rt_q >> 1) + {1'b0, bit_q};
					end else begin
						rt_q <= rt_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						state_q <= ST_DIRX;
					end
				end
				ST_DIRX: ret_q <= ST_DIRY;
				ST_DIRY: begin
					dx_q <= vnegx_q ? -div_quo_q[15:0] : div_quo_q[15:0];
					ret_q <= ST_DIRDONE;
				end
				ST_DIRDONE: begin
					dy_q <= vnegy_q ? -div_quo_q[15:0] : div_quo_q[15:0];
					state_q <= ST_MULX;
				end
				ST_MULX: state_q <= ST_DIVPX;
				ST_DIVPX: ret_q <= ST_POSX;
				ST_POSX: begin
					px_q <= dnegx_q ? (cur_x_q - div_quo_q[31:0]) : (cur_x_q + div_quo_q[31:0]);
					state_q <= ST_DIVPY;
				end
				ST_DIVPY: ret_q <= ST_POSY;
				ST_POSY: begin
					py_q <= py_c;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						o_px_q <= px_q;
						o_py_q <= py_q;
						o_dx_q <= dx_q;
						o_dy_q <= dy_q;
						o_last_q <= last_c;
						o_trunc_q <= last_c && trunc_q;
						if (last_c) begin
							prev_x_q <= cur_x_q;
							prev_y_q <= cur_y_q;
							prev_l_q <= cur_l_q;
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
							num_q <= num_q + {3'b000, s_eff};
							state_q <= ST_MULX;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cfg.ready = 1'b1;
	assign points.ready = state_q == ST_IDLE;
	assign results.valid = out_valid_q;
	assign results.pos_x = o_px_q;
	assign results.pos_y = o_py_q;
	assign results.dir_x = o_dx_q;
	assign results.dir_y = o_dy_q;
	assign results.last_of_segment = o_last_q;
	assign results.truncated = o_trunc_q;

	assign start_acc = points.valid && points.ready && points.curve_start;
	assign trunc_ok = !results.truncated || results.last_of_segment;
	assign dir_ok = (results.dir_x <= 16'sd16384) && (results.dir_x >= -16'sd16384)
		&& (results.dir_y <= 16'sd16384) && (results.dir_y >= -16'sd16384);

	`PLCA_ASSERT_NXT(a_start_no_seg, clk, arst_n, start_acc, state_q == ST_IDLE, "start formed a segment")
	`PLCA_ASSERT_IMP(a_trunc_last, clk, arst_n, results.valid, trunc_ok, "truncated on a non-last result")
	`PLCA_ASSERT_IMP(a_dir_range, clk, arst_n, results.valid, dir_ok, "direction component exceeds one")
endmodule
